// ===== rtl/core/tch_pkg.sv =====
// shared types and constants of the trimer code histogram
`default_nettype none

package tch_pkg;

   // histogram geometry
   localparam int TCH_NUM_BINS    = 64;
   localparam int TCH_BIN_W       = 6;
   localparam int TCH_CHAR_W      = 8;
   localparam int TCH_BASE_W      = 2;
   localparam int TCH_COUNT_OUT_W = 16;

   // parameter defaults
   localparam int unsigned TCH_COUNT_MAX   = 32'd65535;
   localparam int          TCH_QUEUE_DEPTH = 4;

   // bases of a sequence counted before a trimer is formed
   localparam logic [1:0] TCH_SEEN_FULL = 2'd2;

   // request kinds on the input channel
   localparam logic REQ_BASE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // result kinds on the output channel
   localparam logic RSP_TRIMER = 1'b0;
   localparam logic RSP_COUNT  = 1'b1;

   // command codes between front and back
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_COUNT = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]           kind;
      logic [TCH_BIN_W-1:0] bin;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/tch_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module tch_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tch_front.sv =====
// front end: base window, sequence tracking and command classification
`default_nettype none

module tch_front
   import tch_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  req_req_type,
   input  wire logic [TCH_CHAR_W-1:0] req_base_char,
   input  wire logic                  req_first_base,
   input  wire logic [TCH_BIN_W-1:0]  req_bin_index,
   output      logic                  push,
   output      cmd_type               push_cmd
);

   logic [TCH_BASE_W-1:0] older_ff, older_in;
   logic [TCH_BASE_W-1:0] newer_ff, newer_in;
   logic [1:0]            seen_ff, seen_in;

   logic [TCH_BASE_W-1:0] code;
   logic [TCH_BASE_W-1:0] older_base;
   logic [TCH_BASE_W-1:0] newer_base;
   logic [1:0]            seen_base;
   logic                  emit;
   logic                  is_base;

   // window as seen by this base, after an optional sequence restart
   always_comb begin
      is_base    = accept && (req_req_type == REQ_BASE);
      code       = req_base_char[2:1];
      older_base = req_first_base ? '0 : older_ff;
      newer_base = req_first_base ? '0 : newer_ff;
      seen_base  = req_first_base ? '0 : seen_ff;
      emit       = (seen_base == TCH_SEEN_FULL);
   end

   // next window state
   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      seen_in  = seen_ff;
      if (is_base) begin
         older_in = newer_base;
         newer_in = code;
         seen_in  = emit ? TCH_SEEN_FULL : seen_base + 2'd1;
      end
   end

   // command toward the back end
   always_comb begin
      push          = 1'b0;
      push_cmd.kind = CMD_CLEAR;
      push_cmd.bin  = '0;
      if (accept) begin
         if (req_req_type == REQ_READ) begin
            push          = 1'b1;
            push_cmd.kind = CMD_READ;
            push_cmd.bin  = req_bin_index;
         end else if (req_first_base) begin
            push          = 1'b1;
            push_cmd.kind = CMD_CLEAR;
         end else if (emit) begin
            push          = 1'b1;
            push_cmd.kind = CMD_COUNT;
            push_cmd.bin  = {older_base, newer_base, code};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         seen_ff  <= '0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         seen_ff  <= seen_in;
      end
   end

   // a trimer is only formed once two earlier bases are held
   assert property (@(posedge clock) disable iff (reset)
      (push && (push_cmd.kind == CMD_COUNT)) |-> (seen_ff == TCH_SEEN_FULL))
      else $error("trimer formed before two bases were seen");

endmodule

`default_nettype wire

// ===== rtl/core/tch_queue.sv =====
// short command queue between front and back end
`default_nettype none

module tch_queue
   import tch_pkg::*;
#(
   parameter int DEPTH = TCH_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output      logic    full,
   output      logic    head_vld,
   output      cmd_type head_cmd
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   // status
   assign full     = (cnt_ff == CntW'(DEPTH));
   assign head_vld = (cnt_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill count update, pointers wrap at the last slot
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> head_vld)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== rtl/core/tch_back.sv =====
// back end: histogram read-modify-write pipeline and result register
`default_nettype none

module tch_back
   import tch_pkg::*;
#(
   parameter int unsigned COUNT_MAX = TCH_COUNT_MAX
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_vld,
   input  wire cmd_type                    head_cmd,
   output      logic                       pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_result_kind,
   output      logic [TCH_BIN_W-1:0]       rsp_trimer_code,
   output      logic [TCH_COUNT_OUT_W-1:0] rsp_bin_count
);

   localparam int CntW = $clog2(64'(COUNT_MAX) + 64'd1);

   // histogram entry valid bits, cleared by reset or a sequence restart
   logic [TCH_NUM_BINS-1:0] valid_ff, valid_in;

   // lookup stage
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_read_ff;
   logic [TCH_BIN_W-1:0] s1_bin_ff;
   logic                 s1_fwd_ff;
   logic [CntW-1:0]      s1_fwd_data_ff;
   logic                 s1_ent_ff;

   // result register
   logic                       out_vld_ff, out_vld_in;
   logic                       out_kind_ff;
   logic [TCH_BIN_W-1:0]       out_code_ff;
   logic [TCH_COUNT_OUT_W-1:0] out_count_ff;

   logic            cmd_clear;
   logic            can_take;
   logic            s1_adv;
   logic            rd_en;
   logic [CntW-1:0] rd_data;
   logic [CntW-1:0] cur_cnt;
   logic            at_max;
   logic            wr_en;
   logic [CntW-1:0] wr_data;

   // pipeline flow
   always_comb begin
      cmd_clear = (head_cmd.kind == CMD_CLEAR);
      can_take  = !out_vld_ff || rsp_ready;
      s1_adv    = s1_vld_ff && can_take;
      pop       = head_vld && (!s1_vld_ff || can_take);
      rd_en     = pop && !cmd_clear;
   end

   // current count with bypass of the write issued alongside the read
   always_comb begin
      if (s1_fwd_ff) begin
         cur_cnt = s1_fwd_data_ff;
      end else if (s1_ent_ff) begin
         cur_cnt = rd_data;
      end else begin
         cur_cnt = '0;
      end
      at_max  = (cur_cnt == CntW'(COUNT_MAX));
      wr_en   = s1_adv && !s1_read_ff;
      wr_data = at_max ? cur_cnt : cur_cnt + CntW'(1);
   end

   tch_ram #(
      .WIDTH (CntW),
      .DEPTH (TCH_NUM_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_bin_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_cmd.bin),
      .rd_data (rd_data)
   );

   // valid bits: a restart wins over the older write in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[s1_bin_ff] = 1'b1;
      end
      if (pop && cmd_clear) begin
         valid_in = '0;
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (pop) begin
         s1_vld_in = !cmd_clear;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // lookup stage payload
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_read_ff     <= (head_cmd.kind == CMD_READ);
         s1_bin_ff      <= head_cmd.bin;
         s1_fwd_ff      <= wr_en && (s1_bin_ff == head_cmd.bin);
         s1_fwd_data_ff <= wr_data;
         s1_ent_ff      <= valid_ff[head_cmd.bin];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_kind_ff  <= s1_read_ff ? RSP_COUNT : RSP_TRIMER;
         out_code_ff  <= s1_read_ff ? '0 : s1_bin_ff;
         out_count_ff <= s1_read_ff ? TCH_COUNT_OUT_W'(cur_cnt) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_trimer_code = out_code_ff;
   assign rsp_bin_count   = out_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      (pop && cmd_clear) |=> (valid_ff == '0))
      else $error("histogram not cleared by sequence restart");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data <= CntW'(COUNT_MAX)))
      else $error("histogram count beyond saturation limit");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_kind_ff == RSP_TRIMER)) |-> (out_count_ff == '0))
      else $error("trimer result carries a nonzero count");

endmodule

`default_nettype wire

// ===== rtl/core/trimer_code_histogram.sv =====
// top level of the trimer code histogram
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   req_type, base_char, first_base, bin_index
//   rsp_      out         rsp_valid / rsp_ready   result_kind, trimer_code, bin_count
//
// one item per cycle sustained while rsp_ready stays high; after its transfer a result is registered in turn in
// the command queue, the histogram ram read and the result register
// back-to-back counts on the same bin are bypassed around the ram write
// reset clears the window, the queue and all histogram valid bits at once
// a 4-entry command queue absorbs result stalls; req_ready drops when it is full
`default_nettype none

module trimer_code_histogram
   import tch_pkg::*;
#(
   parameter int unsigned COUNT_MAX   = TCH_COUNT_MAX,
   parameter int          QUEUE_DEPTH = TCH_QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic                       req_req_type,
   input  wire logic [TCH_CHAR_W-1:0]      req_base_char,
   input  wire logic                       req_first_base,
   input  wire logic [TCH_BIN_W-1:0]       req_bin_index,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic                       rsp_result_kind,
   output      logic [TCH_BIN_W-1:0]       rsp_trimer_code,
   output      logic [TCH_COUNT_OUT_W-1:0] rsp_bin_count
);

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_vld;
   cmd_type q_head;
   logic    pop;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   tch_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_req_type   (req_req_type),
      .req_base_char  (req_base_char),
      .req_first_base (req_first_base),
      .req_bin_index  (req_bin_index),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   tch_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .head_vld (q_vld),
      .head_cmd (q_head)
   );

   tch_back #(
      .COUNT_MAX (COUNT_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_vld        (q_vld),
      .head_cmd        (q_head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_trimer_code (rsp_trimer_code),
      .rsp_bin_count   (rsp_bin_count)
   );

endmodule

`default_nettype wire

// ===== tb/tch_reply_monitor.sv =====
// transfer monitor, histogram predictor and reply comparison for trimer_code_histogram
`timescale 1ns / 100ps

module tch_reply_monitor
   import tch_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       req_req_type,
   input  wire logic [TCH_CHAR_W-1:0]      req_base_char,
   input  wire logic                       req_first_base,
   input  wire logic [TCH_BIN_W-1:0]       req_bin_index,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic                       rsp_result_kind,
   input  wire logic [TCH_BIN_W-1:0]       rsp_trimer_code,
   input  wire logic [TCH_COUNT_OUT_W-1:0] rsp_bin_count,
   output int                              replies_due,
   output int                              mismatches
);

   // one reply as the block should send it
   typedef struct packed {
      logic                       kind;
      logic [TCH_BIN_W-1:0]       code;
      logic [TCH_COUNT_OUT_W-1:0] count;
   } reply_type;

   reply_type             expected_replies[$];
   logic [TCH_BASE_W-1:0] older_code;
   logic [TCH_BASE_W-1:0] newer_code;
   logic [1:0]            window_fill;
   int unsigned           bin_counts[TCH_NUM_BINS];
   int                    fail_tally;

   initial begin
      replies_due = 0;
      mismatches  = 0;
      fail_tally  = 0;
   end

   // new sequence: empty window and histogram
   task automatic clear_sequence();
      older_code  = '0;
      newer_code  = '0;
      window_fill = '0;
      foreach (bin_counts[i]) bin_counts[i] = 0;
   endtask

   // shift one base into the window, count the trimer once the window is full
   task automatic take_base(input logic [TCH_CHAR_W-1:0] ch, input logic first);
      logic [TCH_BASE_W-1:0] code;
      logic [TCH_BIN_W-1:0]  trimer;
      reply_type             r;
      if (first) clear_sequence();
      code = ch[2:1];
      if (window_fill == TCH_SEEN_FULL) begin
         trimer = {older_code, newer_code, code};
         if (bin_counts[trimer] < TCH_COUNT_MAX) bin_counts[trimer]++;
         r.kind  = RSP_TRIMER;
         r.code  = trimer;
         r.count = '0;
         expected_replies.push_back(r);
      end else begin
         window_fill++;
      end
      older_code = newer_code;
      newer_code = code;
   endtask

   // a read changes nothing, first_base included
   task automatic read_bin(input logic [TCH_BIN_W-1:0] idx);
      reply_type r;
      r.kind  = RSP_COUNT;
      r.code  = '0;
      r.count = bin_counts[idx][TCH_COUNT_OUT_W-1:0];
      expected_replies.push_back(r);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_tally++;
         $error("%s expected %0d actual %0d", name, want, got);
      end
   endtask

   // reply transfer against the oldest expectation
   task automatic check_reply();
      reply_type want;
      if (expected_replies.size() == 0) begin
         fail_tally++;
         $error("unexpected reply: result_kind %0d trimer_code %0d bin_count %0d",
                rsp_result_kind, rsp_trimer_code, rsp_bin_count);
      end else begin
         want = expected_replies.pop_front();
         compare_field("result_kind", want.kind, rsp_result_kind);
         compare_field("trimer_code", want.code, rsp_trimer_code);
         compare_field("bin_count", want.count, rsp_bin_count);
      end
   endtask

   // replies first: one accepted at this edge can not stem from a request of this edge
   always @(posedge clock) begin
      if (reset) begin
         clear_sequence();
         expected_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_reply();
         if (req_valid && req_ready) begin
            if (req_req_type == REQ_READ) read_bin(req_bin_index);
            else take_base(req_base_char, req_first_base);
         end
      end
      replies_due <= expected_replies.size();
      mismatches  <= fail_tally;
   end

endmodule

// ===== tb/tb_trimer_code_histogram.sv =====
// stimulus and verdict for the trimer code histogram
`timescale 1ns / 100ps

module tb_trimer_code_histogram;
   import tch_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_req_type = REQ_BASE;
   logic [TCH_CHAR_W-1:0]      req_base_char = '0;
   logic                       req_first_base = 1'b0;
   logic [TCH_BIN_W-1:0]       req_bin_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_result_kind;
   logic [TCH_BIN_W-1:0]       rsp_trimer_code;
   logic [TCH_COUNT_OUT_W-1:0] rsp_bin_count;

   int replies_due;
   int mismatches;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   trimer_code_histogram dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_req_type    (req_req_type),
      .req_base_char   (req_base_char),
      .req_first_base  (req_first_base),
      .req_bin_index   (req_bin_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_trimer_code (rsp_trimer_code),
      .rsp_bin_count   (rsp_bin_count)
   );

   tch_reply_monitor monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_req_type    (req_req_type),
      .req_base_char   (req_base_char),
      .req_first_base  (req_first_base),
      .req_bin_index   (req_bin_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_trimer_code (rsp_trimer_code),
      .rsp_bin_count   (rsp_bin_count),
      .replies_due     (replies_due),
      .mismatches      (mismatches)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reply side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request transfer, with random idle cycles before it; valid stays up afterwards
   task automatic send_item(input logic kind, input logic [TCH_CHAR_W-1:0] ch,
                            input logic first, input logic [TCH_BIN_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_req_type   <= kind;
      req_base_char  <= ch;
      req_first_base <= first;
      req_bin_index  <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_base(input logic [TCH_CHAR_W-1:0] ch, input logic first);
      send_item(REQ_BASE, ch, first, 6'($urandom_range(63)));
   endtask

   task automatic send_read(input logic [TCH_BIN_W-1:0] idx, input logic first);
      send_item(REQ_READ, 8'($urandom_range(255)), first, idx);
   endtask

   // hold off until every outstanding reply has been transferred
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
   endtask

   // mostly real nucleotide letters, some arbitrary bytes
   function automatic logic [TCH_CHAR_W-1:0] pick_char();
      case ($urandom_range(4))
         0: pick_char = "A";
         1: pick_char = "C";
         2: pick_char = "G";
         3: pick_char = "T";
         default: pick_char = 8'($urandom_range(255));
      endcase
   endfunction

   // random sequences with occasional restarts and reads
   task automatic run_random(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) send_read(6'($urandom_range(63)), 1'($urandom_range(1)));
         else if (pick < 19) send_base(pick_char(), 1'b1);
         else send_base(pick_char(), 1'b0);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 21;
      recv_idle_pct = 85;

      // empty histogram; first_base on a read has no effect
      send_read(6'd0, 1'b1);
      send_read(6'h3F, 1'b0);
      // stream starts at reset without first_base
      send_base("A", 1'b0);
      send_base("C", 1'b0);
      send_base("G", 1'b0);
      send_base("T", 1'b0);
      // only bits 2:1 of the character matter
      send_base(8'hFF, 1'b0);
      send_base(8'h00, 1'b0);
      send_base(8'hF9, 1'b0);
      send_base(8'h06, 1'b0);
      send_read(6'h3F, 1'b0);
      send_read(6'h3C, 1'b1);
      // two-base sequence ends before any trimer is formed
      send_base("T", 1'b1);
      send_base("T", 1'b0);
      send_base("G", 1'b1);
      send_base("G", 1'b0);
      send_base("G", 1'b0);
      send_base("G", 1'b0);
      send_read(6'h3F, 1'b0);
      send_read(6'h2A, 1'b0);
      send_read(6'h3C, 1'b0);
      run_random(380);
      drain();

      // phase two: the other way round
      send_idle_pct = 85;
      recv_idle_pct = 21;
      run_random(380);
      drain();

      // phase three: no idling; long run of one base hammers bin zero
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_base("A", 1'b1);
      repeat (240) send_base("A", 1'b0);
      send_read(6'd0, 1'b0);
      send_read(6'd1, 1'b0);
      send_base("C", 1'b0);
      send_read(6'd1, 1'b0);
      run_random(380);

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
